// File: src/job_queue_with_min_extract_macros.svh
// Assertion macros shared by the job queue design.
`ifndef JOB_QUEUE_WITH_MIN_EXTRACT_MACROS_SVH
`define JOB_QUEUE_WITH_MIN_EXTRACT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define JQME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define JQME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/jqme_pkg.sv
// Shared types, codes and constants of the job queue.
package jqme_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LIMIT_W         = 17;
    localparam int PAGES_W         = 16;
    localparam int HELD_W          = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd100;

    localparam logic [1:0] ACT_ENQUEUE  = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE  = 2'd1;
    localparam logic [1:0] ACT_PRIORITY = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_NONE  = 2'd3;

    typedef struct packed {
        logic [PAGES_W-1:0] pages;
        logic [7:0]         tail;
        logic [63:0]        head;
        logic [31:0]        id;
    } job_t;

    // Running best candidate handed from cell to cell
    typedef struct packed {
        logic found;
        job_t job;
    } scan_t;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic held;
        logic wr;
        logic shift;
    } cell_ctl_t;

endpackage

// File: src/job_queue_with_min_extract.sv
// Top level of the job queue with oldest-first and smallest-eligible removal.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tuser: action; tdata: job
//  m_        out  m_tvalid/m_tready  tuser: status; tdata: job, jobs held
//  cfg_      in   cfg_wr_en          cfg_wr_data: priority page limit
//
// Enqueue, dequeue and the unused action register their result in the cycle after accept.
// Priority removal: the candidate walks the cell chain one cell per cycle; once the
// output register is free, the found job is removed and the rest shift up.
// Reset (aresetn low, synchronous) empties the queue and sets the limit to 100.
// A result waits in the output register; an item is accepted while no priority
// search runs and that register is empty or being taken.
`include "job_queue_with_min_extract_macros.svh"

module job_queue_with_min_extract #(
    parameter int QUEUE_DEPTH = jqme_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    s_tuser,  // action
    input  logic [119:0]                  s_tdata,  // job_id, name_head, name_tail,
                                                    // page_count
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [1:0]                    m_tuser,  // status
    output logic [127:0]                  m_tdata,  // out_job_id, out_name_head,
                                                    // out_name_tail, out_page_count,
                                                    // jobs_held, zero pad
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [jqme_pkg::LIMIT_W-1:0]  cfg_wr_data
);
    import jqme_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic               m_tvalid_reg;
    logic [1:0]         m_status_reg;
    job_t               m_job_reg;
    logic [HELD_W-1:0]  m_held_reg;

    logic               accept, out_free;
    logic               res_load;
    logic [1:0]         res_status;
    job_t               res_job;
    logic               wr_any, shift_any;
    logic [IDX_W-1:0]   pos;
    job_t               in_job;

    job_t               jobs [QUEUE_DEPTH];
    scan_t              chain [QUEUE_DEPTH];
    logic [IDX_W-1:0]   chain_idx [QUEUE_DEPTH];
    scan_t              scan_init;

    assign in_job.id    = s_tdata[31:0];
    assign in_job.head  = s_tdata[95:32];
    assign in_job.tail  = s_tdata[103:96];
    assign in_job.pages = s_tdata[119:104];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign scan_init.found = 1'b0;
    assign scan_init.job   = '0;

    // Build the cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_ctl_t        ctl;
        scan_t            sc_in;
        logic [IDX_W-1:0] ix_in;
        job_t             nx_job;

        assign ctl.held  = OCC_W'(i) < occ_reg;
        assign ctl.wr    = wr_any && (occ_reg == OCC_W'(i));
        assign ctl.shift = shift_any && (IDX_W'(i) >= pos);

        if (i == 0) begin : g_head
            assign sc_in = scan_init;
            assign ix_in = '0;
        end else begin : g_body
            assign sc_in = chain[i-1];
            assign ix_in = chain_idx[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nx_job = '0;
        end else begin : g_more
            assign nx_job = jobs[i+1];
        end

        jqme_cell #(
            .IDX   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk         (aclk),
            .ctl          (ctl),
            .limit        (limit_reg),
            .wr_job       (in_job),
            .next_job     (nx_job),
            .scan_in      (sc_in),
            .scan_idx_in  (ix_in),
            .job          (jobs[i]),
            .scan_out     (chain[i]),
            .scan_idx_out (chain_idx[i])
        );
    end

    // Decode the action and sequence the priority search
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        occ_next   = occ_reg;
        res_load   = 1'b0;
        res_status = STAT_DONE;
        res_job    = '0;
        wr_any     = 1'b0;
        shift_any  = 1'b0;
        pos        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        ACT_ENQUEUE: begin
                            res_load = 1'b1;
                            if (occ_reg == OCC_FULL) begin
                                res_status = STAT_FULL;
                            end else begin
                                wr_any   = 1'b1;
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                        ACT_DEQUEUE: begin
                            res_load = 1'b1;
                            if (occ_reg == '0) begin
                                res_status = STAT_EMPTY;
                            end else begin
                                shift_any = 1'b1;
                                res_job   = jobs[0];
                                occ_next  = occ_reg - OCC_W'(1);
                            end
                        end
                        ACT_PRIORITY: begin
                            if (occ_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = STAT_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                                cnt_next   = '0;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (cnt_reg != CNT_LAST) begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end else if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (chain[QUEUE_DEPTH-1].found) begin
                        shift_any = 1'b1;
                        pos       = chain_idx[QUEUE_DEPTH-1];
                        res_job   = chain[QUEUE_DEPTH-1].job;
                        occ_next  = occ_reg - OCC_W'(1);
                    end else begin
                        res_status = STAT_NONE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and page limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            occ_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            occ_reg   <= occ_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status_reg <= res_status;
            m_job_reg    <= res_job;
            m_held_reg   <= HELD_W'(occ_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_held_reg, m_job_reg.pages, m_job_reg.tail,
                       m_job_reg.head, m_job_reg.id};

    // Checks
    `JQME_ASSERT_NOW(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= OCC_FULL,
        "occupancy above queue depth")
    `JQME_ASSERT_NEXT(a_occ_step, aclk, aresetn, 1'b1,
        (occ_reg == $past(occ_reg)) || (occ_reg == $past(occ_reg) + OCC_W'(1))
        || (occ_reg + OCC_W'(1) == $past(occ_reg)),
        "occupancy moved by more than one")
    `JQME_ASSERT_NOW(a_no_load_stalled, aclk, aresetn, m_tvalid_reg && !m_tready,
        !res_load, "result loaded over a waiting item")

endmodule

// File: src/jqme_cell.sv
// One queue cell: holds a job and passes the running minimum to its neighbor.
module jqme_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4
) (
    input  logic                            aclk,
    input  jqme_pkg::cell_ctl_t             ctl,
    input  logic [jqme_pkg::LIMIT_W-1:0]    limit,
    input  jqme_pkg::job_t                  wr_job,
    input  jqme_pkg::job_t                  next_job,
    input  jqme_pkg::scan_t                 scan_in,
    input  logic [IDX_W-1:0]                scan_idx_in,
    output jqme_pkg::job_t                  job,
    output jqme_pkg::scan_t                 scan_out,
    output logic [IDX_W-1:0]                scan_idx_out
);
    import jqme_pkg::*;

    job_t               job_reg;
    scan_t              scan_reg;
    scan_t              scan_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [LIMIT_W-1:0] threshold;
    logic               take;

    // Load a new job, or take the neighbor's job to close a gap
    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            job_reg <= wr_job;
        end else if (ctl.shift) begin
            job_reg <= next_job;
        end
    end

    // Replace the candidate when a held job is strictly smaller (or below the limit)
    always_comb begin
        threshold = scan_in.found ? {1'b0, scan_in.job.pages} : limit;
        take      = ctl.held && ({1'b0, job_reg.pages} < threshold);
        if (take) begin
            scan_next.found = 1'b1;
            scan_next.job   = job_reg;
            idx_next        = IDX_W'(IDX);
        end else begin
            scan_next = scan_in;
            idx_next  = scan_idx_in;
        end
    end

    // Advance the candidate one cell per cycle
    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        idx_reg  <= idx_next;
    end

    assign job          = job_reg;
    assign scan_out     = scan_reg;
    assign scan_idx_out = idx_reg;

endmodule
